/* rtl/core/discrete_input_mode_processor_macros.svh */
// Assertion macros for the RTL; dimp_merge.sv is the file that includes them.
// DIMP_ASSERT checks a property outside reset; DIMP_ASSERT_ALWAYS checks it at every edge.
`ifndef DISCRETE_INPUT_MODE_PROCESSOR_MACROS_SVH
`define DISCRETE_INPUT_MODE_PROCESSOR_MACROS_SVH

`ifndef ASSERT_OFF
`define DIMP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define DIMP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define DIMP_ASSERT(lbl, clk, rst_n, prop)
`define DIMP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/core/dimp_pkg.sv */
package dimp_pkg;

	// Request codes carried by req_type
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_SET   = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// Channel mode codes
	localparam logic [3:0] MODE_LOW      = 4'd0;
	localparam logic [3:0] MODE_HIGH     = 4'd1;
	localparam logic [3:0] MODE_DIRECT   = 4'd2;
	localparam logic [3:0] MODE_INVERT   = 4'd3;
	localparam logic [3:0] MODE_CNT_FALL = 4'd4;
	localparam logic [3:0] MODE_CNT_RISE = 4'd5;
	localparam logic [3:0] MODE_CNT_BOTH = 4'd6;
	localparam logic [3:0] MODE_TGL_FALL = 4'd7;
	localparam logic [3:0] MODE_TGL_RISE = 4'd8;

	// Register indexes (paddr[2])
	localparam logic REG_MODE_SELECT   = 1'b0;
	localparam logic REG_BYPASS_ENABLE = 1'b1;

	localparam logic [31:0] MODE_RESET = 32'h2222_2222;
	localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

	localparam int VALUE_W = 32;
	localparam int MAX_CH  = 8;

	// Per-lane control for one transaction
	typedef struct packed {
		logic                go;
		req_t                req;
		logic                pin;
		logic                sel;
		logic                bypass;
		logic [3:0]          mode;
		logic [VALUE_W-1:0]  new_value;
	} lane_ctrl_t;

endpackage

/* rtl/core/dimp_lane.sv */
module dimp_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dimp_pkg::lane_ctrl_t              ctrl,
	output logic [dimp_pkg::VALUE_W-1:0]      value,
	output logic                              nz_next
);

	logic [dimp_pkg::VALUE_W-1:0] value_q;
	logic [dimp_pkg::VALUE_W-1:0] value_next;
	logic                         prev_q;
	logic                         prev_next;
	logic                         fall;
	logic                         rise;
	logic                         tick;

	assign fall = prev_q & ~ctrl.pin;
	assign rise = ~prev_q & ctrl.pin;
	assign tick = ctrl.go && (ctrl.req == dimp_pkg::REQ_TICK) && !ctrl.bypass;

	// Compute the channel's next value and previous level
	always_comb begin
		value_next = value_q;
		prev_next  = prev_q;
		if (tick) begin
			case (ctrl.mode) inside
				dimp_pkg::MODE_LOW:    value_next = '0;
				dimp_pkg::MODE_HIGH:   value_next = 32'd1;
				dimp_pkg::MODE_DIRECT: value_next = {31'd0, ctrl.pin};
				dimp_pkg::MODE_INVERT: value_next = {31'd0, ~ctrl.pin};
				dimp_pkg::MODE_CNT_FALL, dimp_pkg::MODE_CNT_RISE,
				dimp_pkg::MODE_CNT_BOTH: begin
					prev_next = ctrl.pin;
					if (((ctrl.mode == dimp_pkg::MODE_CNT_FALL) && fall) ||
					    ((ctrl.mode == dimp_pkg::MODE_CNT_RISE) && rise) ||
					    ((ctrl.mode == dimp_pkg::MODE_CNT_BOTH) && (fall || rise))) begin
						if (value_q != dimp_pkg::COUNT_MAX)
							value_next = 32'(value_q + 32'd1);
					end
				end
				dimp_pkg::MODE_TGL_FALL, dimp_pkg::MODE_TGL_RISE: begin
					prev_next = ctrl.pin;
					if (((ctrl.mode == dimp_pkg::MODE_TGL_FALL) && fall) ||
					    ((ctrl.mode == dimp_pkg::MODE_TGL_RISE) && rise))
						value_next = (value_q != '0) ? '0 : 32'd1;
				end
				default: ;
			endcase
		end else if (ctrl.go && ctrl.sel && (ctrl.req == dimp_pkg::REQ_CLEAR)) begin
			// Clear only takes effect in the counting modes
			case (ctrl.mode) inside
				dimp_pkg::MODE_CNT_FALL, dimp_pkg::MODE_CNT_RISE,
				dimp_pkg::MODE_CNT_BOTH: value_next = '0;
				default: ;
			endcase
		end else if (ctrl.go && ctrl.sel && ctrl.bypass && (ctrl.req == dimp_pkg::REQ_SET)) begin
			value_next = ctrl.new_value;
		end
	end

	// Hold channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			prev_q  <= 1'b0;
		end else begin
			value_q <= value_next;
			prev_q  <= prev_next;
		end
	end

	assign value   = value_q;
	assign nz_next = (value_next != '0);

endmodule

/* rtl/core/dimp_merge.sv */
`include "discrete_input_mode_processor_macros.svh"

module dimp_merge #(
	parameter int CHANNELS = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        push,
	input  dimp_pkg::req_t                              req,
	input  logic [2:0]                                  channel,
	input  logic [CHANNELS-1:0][dimp_pkg::VALUE_W-1:0]  values,
	input  logic [CHANNELS-1:0]                         nz,
	output logic                                        full,
	output logic                                        rsp_valid,
	input  logic                                        rsp_stall,
	output logic [dimp_pkg::VALUE_W-1:0]                read_value,
	output logic [dimp_pkg::MAX_CH-1:0]                 level_bits
);

	logic [dimp_pkg::VALUE_W-1:0] rd_new;
	logic [dimp_pkg::MAX_CH-1:0]  lv_new;
	logic                         main_v_q;
	logic                         skid_v_q;
	logic [dimp_pkg::VALUE_W-1:0] main_rd_q;
	logic [dimp_pkg::MAX_CH-1:0]  main_lv_q;
	logic [dimp_pkg::VALUE_W-1:0] skid_rd_q;
	logic [dimp_pkg::MAX_CH-1:0]  skid_lv_q;
	logic                         pop;

	// Select the addressed lane on a read and gather the level bits
	always_comb begin
		rd_new = '0;
		if (req == dimp_pkg::REQ_READ) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (channel == 3'(i))
					rd_new = values[i];
			end
		end
		lv_new = '0;
		lv_new[CHANNELS-1:0] = nz;
	end

	assign pop = main_v_q && !rsp_stall;

	// Advance the two-entry result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop && skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else if (push && (!main_v_q || pop)) begin
				main_v_q <= 1'b1;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end else if (pop) begin
				main_v_q <= 1'b0;
			end
		end
	end

	// Move payload alongside the valid bits
	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			main_rd_q <= skid_rd_q;
			main_lv_q <= skid_lv_q;
		end else if (push && (!main_v_q || pop)) begin
			main_rd_q <= rd_new;
			main_lv_q <= lv_new;
		end
		if (push && main_v_q && !pop) begin
			skid_rd_q <= rd_new;
			skid_lv_q <= lv_new;
		end
	end

	assign full       = skid_v_q;
	assign rsp_valid  = main_v_q;
	assign read_value = main_rd_q;
	assign level_bits = main_lv_q;

	`DIMP_ASSERT(a_skid_needs_main, clk, arst_n, skid_v_q |-> main_v_q)
	`DIMP_ASSERT(a_skid_fill, clk, arst_n, (push && main_v_q && rsp_stall) |=> skid_v_q)
	`DIMP_ASSERT(a_skid_drain, clk, arst_n, (pop && skid_v_q) |=> (main_v_q && !skid_v_q))
	`DIMP_ASSERT(a_no_push_full, clk, arst_n, push |-> !skid_v_q)

endmodule

/* rtl/core/discrete_input_mode_processor.sv */
// Discrete input mode processor: CHANNELS lanes, one per discrete input, each
// update their channel value in parallel, so the block takes one transaction
// every clock while req_stall is low and registers each result in a two-entry
// output buffer. The buffer lets one more transaction be taken while a result
// is stalled; req_stall rises only once both entries are full.
// Configuration (mode_select at 0x0, bypass_enable at 0x4) must be written over the
// APB port only while no transaction is in flight; the block does not enforce it.
module discrete_input_mode_processor #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  pin_levels,
	input  logic [2:0]  channel,
	input  logic [31:0] new_value,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] read_value,
	output logic [7:0]  level_bits
);

	logic [31:0]                               mode_q;
	logic [7:0]                                bypass_q;
	logic                                      accept;
	logic                                      full;
	dimp_pkg::req_t                            req;
	logic [CHANNELS-1:0][dimp_pkg::VALUE_W-1:0] values;
	logic [CHANNELS-1:0]                       nz;

	assign pready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= dimp_pkg::MODE_RESET;
			bypass_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				dimp_pkg::REG_MODE_SELECT:   mode_q   <= pwdata;
				dimp_pkg::REG_BYPASS_ENABLE: bypass_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Return register contents on reads
	always_comb begin
		unique case (paddr[2])
			dimp_pkg::REG_MODE_SELECT:   prdata = mode_q;
			dimp_pkg::REG_BYPASS_ENABLE: prdata = {24'd0, bypass_q};
			default:                     prdata = '0;
		endcase
	end

	assign req_stall = full;
	assign accept    = req_valid && !full;
	assign req       = dimp_pkg::req_t'(req_type);

	// One lane per channel
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		dimp_pkg::lane_ctrl_t ctrl;

		always_comb begin
			ctrl.go        = accept;
			ctrl.req       = req;
			ctrl.pin       = pin_levels[i];
			ctrl.sel       = (channel == 3'(i));
			ctrl.bypass    = bypass_q[i];
			ctrl.mode      = mode_q[4*i +: 4];
			ctrl.new_value = new_value;
		end

		dimp_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.value   (values[i]),
			.nz_next (nz[i])
		);
	end

	dimp_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.req        (req),
		.channel    (channel),
		.values     (values),
		.nz         (nz),
		.full       (full),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.level_bits (level_bits)
	);

endmodule

/* sim/discrete_input_mode_processor_check.sv */
`timescale 1ns / 1ps

module discrete_input_mode_processor_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  pin_levels,
	input  logic [2:0]  channel,
	input  logic [31:0] new_value,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [31:0] read_value,
	input  logic [7:0]  level_bits,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] read_value;
		logic [7:0]  level_bits;
	} report_t;

	// Shadow of the block's registers and channel state
	logic [31:0] mode_reg;
	logic [7:0]  bypass_reg;
	logic [31:0] chan_val [dimp_pkg::MAX_CH];
	logic        prev_lvl [dimp_pkg::MAX_CH];
	report_t     report_q [$];

	// Advance one channel on a sample tick
	task automatic tick_lane(input int ch, input logic pin);
		logic [3:0] mode;
		logic       fall;
		logic       rise;
		logic       edge_seen;
		mode = mode_reg[4*ch +: 4];
		fall = prev_lvl[ch] && !pin;
		rise = !prev_lvl[ch] && pin;
		case (mode)
			dimp_pkg::MODE_LOW:    chan_val[ch] = '0;
			dimp_pkg::MODE_HIGH:   chan_val[ch] = 32'd1;
			dimp_pkg::MODE_DIRECT: chan_val[ch] = {31'd0, pin};
			dimp_pkg::MODE_INVERT: chan_val[ch] = {31'd0, !pin};
			dimp_pkg::MODE_CNT_FALL, dimp_pkg::MODE_CNT_RISE, dimp_pkg::MODE_CNT_BOTH: begin
				if (mode == dimp_pkg::MODE_CNT_FALL)
					edge_seen = fall;
				else if (mode == dimp_pkg::MODE_CNT_RISE)
					edge_seen = rise;
				else
					edge_seen = fall || rise;
				// saturate at the top of the count range
				if (edge_seen && chan_val[ch] != dimp_pkg::COUNT_MAX)
					chan_val[ch] = chan_val[ch] + 32'd1;
				prev_lvl[ch] = pin;
			end
			dimp_pkg::MODE_TGL_FALL: begin
				if (fall)
					chan_val[ch] = (chan_val[ch] != '0) ? 32'd0 : 32'd1;
				prev_lvl[ch] = pin;
			end
			dimp_pkg::MODE_TGL_RISE: begin
				if (rise)
					chan_val[ch] = (chan_val[ch] != '0) ? 32'd0 : 32'd1;
				prev_lvl[ch] = pin;
			end
			// undefined codes hold value and previous level
			default: ;
		endcase
	endtask

	// Apply one transaction to the shadow state and form its report
	task automatic apply_transaction(input dimp_pkg::req_t rq, input logic [7:0] pins,
			input logic [2:0] ch, input logic [31:0] nv, output report_t rpt);
		logic [3:0] mode;
		rpt = '0;
		mode = mode_reg[4*ch +: 4];
		case (rq)
			dimp_pkg::REQ_TICK: begin
				for (int i = 0; i < dimp_pkg::MAX_CH; i++)
					if (!bypass_reg[i])
						tick_lane(i, pins[i]);
			end
			dimp_pkg::REQ_CLEAR: begin
				if (mode >= dimp_pkg::MODE_CNT_FALL && mode <= dimp_pkg::MODE_CNT_BOTH)
					chan_val[ch] = '0;
			end
			dimp_pkg::REQ_SET: begin
				if (bypass_reg[ch])
					chan_val[ch] = nv;
			end
			dimp_pkg::REQ_READ: rpt.read_value = chan_val[ch];
			default: ;
		endcase
		for (int i = 0; i < dimp_pkg::MAX_CH; i++)
			rpt.level_bits[i] = (chan_val[i] != '0);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		report_t made;
		int      errs;
		if (!arst_n) begin
			mode_reg   = dimp_pkg::MODE_RESET;
			bypass_reg = '0;
			for (int i = 0; i < dimp_pkg::MAX_CH; i++) begin
				chan_val[i] = '0;
				prev_lvl[i] = 1'b0;
			end
			report_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == dimp_pkg::REG_MODE_SELECT)
					mode_reg = pwdata;
				else
					bypass_reg = pwdata[7:0];
			end
			// compare a delivered result against the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (report_q.size() == 0) begin
					$error("unexpected result: read_value %h level_bits %h",
						read_value, level_bits);
					errs++;
				end else begin
					want = report_q.pop_front();
					if (read_value !== want.read_value) begin
						$error("read_value: expected %h, actual %h",
							want.read_value, read_value);
						errs++;
					end
					if (level_bits !== want.level_bits) begin
						$error("level_bits: expected %h, actual %h",
							want.level_bits, level_bits);
						errs++;
					end
				end
			end
			// predict an accepted transaction
			if (req_valid && !req_stall) begin
				apply_transaction(dimp_pkg::req_t'(req_type), pin_levels, channel,
					new_value, made);
				report_q.push_back(made);
			end
			pending    <= report_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

/* sim/discrete_input_mode_processor_test.sv */
`timescale 1ns / 1ps

module discrete_input_mode_processor_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;

	logic           clk        = 1'b0;
	logic           arst_n     = 1'b0;
	logic           psel       = 1'b0;
	logic           penable    = 1'b0;
	logic           pwrite     = 1'b0;
	logic [2:0]     paddr      = '0;
	logic [31:0]    pwdata     = '0;
	logic [31:0]    prdata;
	logic           pready;
	logic           req_valid  = 1'b0;
	logic           req_stall;
	dimp_pkg::req_t req_type   = dimp_pkg::REQ_TICK;
	logic [7:0]     pin_levels = '0;
	logic [2:0]     channel    = '0;
	logic [31:0]    new_value  = '0;
	logic           rsp_valid;
	logic           rsp_stall  = 1'b0;
	logic [31:0]    read_value;
	logic [7:0]     level_bits;

	int fail_count;
	int pending;
	int cycle_count   = 0;
	int send_idle_pct = 12;
	int rsp_stall_pct = 55;
	int hold_seq      = 0;
	int hold_seen     = 0;

	always #10 clk = ~clk;

	discrete_input_mode_processor DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.pin_levels (pin_levels),
		.channel    (channel),
		.new_value  (new_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.level_bits (level_bits)
	);

	discrete_input_mode_processor_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.pin_levels (pin_levels),
		.channel    (channel),
		.new_value  (new_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.level_bits (level_bits),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL discrete_input_mode_processor");
			$finish;
		end
	end

	// Result side: random stall, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
			end
		end
	end

	// Write one register: setup cycle, then access until pready
	task automatic reg_write(input logic reg_idx, input logic [31:0] data);
		logic done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one transaction, holding it until the block takes it
	task automatic offer(input dimp_pkg::req_t rq, input logic [7:0] pins,
			input logic [2:0] ch, input logic [31:0] nv);
		logic taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= rq;
		pin_levels <= pins;
		channel    <= ch;
		new_value  <= nv;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Stop sending and wait for every predicted result, then let the pipe settle
	task automatic drain();
		req_valid <= 1'b0;
		// let the count of the last accepted transaction settle first
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] modes, input logic [7:0] bypass);
		drain();
		reg_write(dimp_pkg::REG_MODE_SELECT, modes);
		reg_write(dimp_pkg::REG_BYPASS_ENABLE, {24'd0, bypass});
	endtask

	// Mostly defined modes, now and then an undefined code
	function automatic logic [31:0] random_modes();
		logic [31:0] m;
		for (int i = 0; i < dimp_pkg::MAX_CH; i++)
			m[4*i +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
		return m;
	endfunction

	// Favor values near the counter limit and near zero
	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 3))
			0: return dimp_pkg::COUNT_MAX - 32'($urandom_range(0, 3));
			1: return 32'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random();
		int             pick;
		dimp_pkg::req_t rq;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			rq = dimp_pkg::REQ_TICK;
		else if (pick < 65)
			rq = dimp_pkg::REQ_CLEAR;
		else if (pick < 80)
			rq = dimp_pkg::REQ_SET;
		else
			rq = dimp_pkg::REQ_READ;
		offer(rq, 8'($urandom), 3'($urandom), random_value());
	endtask

	task automatic run_phase(input logic [31:0] modes, input logic [7:0] bypass,
			input int count, input int idle_pct, input int stall_pct, input bit long_hold);
		configure(modes, bypass);
		send_idle_pct = idle_pct;
		rsp_stall_pct <= stall_pct;
		if (long_hold)
			hold_seq <= hold_seq + 1;
		repeat (count) send_random();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One channel per mode: low, direct, invert, three counters, two toggles
		configure(32'h8765_4320, 8'h00);
		offer(dimp_pkg::REQ_TICK, 8'hFF, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_TICK, 8'h00, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_TICK, 8'hFF, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_TICK, 8'hFF, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_TICK, 8'h00, 3'd0, 32'd0);
		for (int ch = 3; ch < 8; ch++)
			offer(dimp_pkg::REQ_READ, 8'h00, 3'(ch), 32'd0);
		// clear on a counter, clear outside edge modes, set on a live channel
		offer(dimp_pkg::REQ_CLEAR, 8'h00, 3'd3, 32'd0);
		offer(dimp_pkg::REQ_CLEAR, 8'h00, 3'd1, 32'd0);
		offer(dimp_pkg::REQ_SET, 8'h00, 3'd2, 32'h0000_1234);

		// Bypassed: counters loaded near the limit, high and undefined modes
		configure(32'hFEDC_9166, 8'hFF);
		offer(dimp_pkg::REQ_SET, 8'h00, 3'd0, dimp_pkg::COUNT_MAX - 32'd1);
		offer(dimp_pkg::REQ_SET, 8'h00, 3'd1, dimp_pkg::COUNT_MAX);
		offer(dimp_pkg::REQ_SET, 8'h00, 3'd2, 32'h5A5A_5A5A);
		offer(dimp_pkg::REQ_TICK, 8'hFF, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_CLEAR, 8'h00, 3'd1, 32'd0);
		offer(dimp_pkg::REQ_SET, 8'h00, 3'd1, dimp_pkg::COUNT_MAX);
		offer(dimp_pkg::REQ_READ, 8'h00, 3'd1, 32'd0);
		offer(dimp_pkg::REQ_CLEAR, 8'h00, 3'd2, 32'd0);

		// Release the bypass: counters reach and hold the limit
		configure(32'hFEDC_9166, 8'h00);
		offer(dimp_pkg::REQ_TICK, 8'hFF, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_TICK, 8'h00, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_TICK, 8'hFF, 3'd0, 32'd0);
		offer(dimp_pkg::REQ_READ, 8'h00, 3'd0, 32'd0);

		// Random traffic over a spread of settings
		run_phase(dimp_pkg::MODE_RESET, 8'h00, 120, 12, 55, 1'b0);
		run_phase(32'hFFFF_FFFF, 8'hFF, 60, 12, 55, 1'b0);
		run_phase(random_modes(), 8'($urandom), 150, 12, 55, 1'b1);
		run_phase(32'h0000_0000, 8'h0F, 60, 55, 12, 1'b0);
		run_phase($urandom, 8'($urandom), 150, 55, 12, 1'b0);
		run_phase(random_modes(), 8'h00, 150, 0, 0, 1'b1);
		run_phase(32'h6655_4477, 8'($urandom), 160, 0, 0, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS discrete_input_mode_processor");
		else
			$display("FAIL discrete_input_mode_processor");
		$finish;
	end

endmodule
